### src/ctl_pkg.sv
`timescale 1ns / 1ps

package ctl_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int TOTAL_BITS_DEF = 48;
    localparam int RADIUS_BITS    = 16;
    localparam int APB_DATA_W     = 32;
    localparam int APB_ADDR_W     = 3;

    localparam logic                   MODE_CIRCLE  = 1'b0;
    localparam logic                   MODE_SQUARE  = 1'b1;
    localparam logic                   MODE_RESET   = MODE_SQUARE;
    localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = RADIUS_BITS'(256);

    typedef enum logic [0:0] {
        REG_MODE   = 1'b0,
        REG_RADIUS = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_MUL,
        S_SUM,
        S_ROOT,
        S_ACC,
        S_EMIT
    } state_t;

    // Which leg of the current city is being worked on.
    typedef enum logic [0:0] {
        LEG_STEP  = 1'b0,
        LEG_CLOSE = 1'b1
    } leg_t;

    typedef struct packed {
        logic capture;
        leg_t leg_sel;
        logic diff_en;
        logic mul_en;
        logic root_init;
        logic root_step;
        logic acc_en;
        logic emit;
    } ctl_cmd_t;

    typedef struct packed {
        logic have_first;
        logic last;
        logic root_done;
        logic out_free;
        logic mode;
    } ctl_status_t;

endpackage

### src/ctl_if.sv
`timescale 1ns / 1ps

interface ctl_city_if
    import ctl_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] x_coord;
    logic [COORD_BITS-1:0] y_coord;
    logic                  last_city;

    modport source (output valid, output x_coord, output y_coord, output last_city,
                    input ready);
    modport sink (input valid, input x_coord, input y_coord, input last_city,
                  output ready);
endinterface

interface ctl_tour_if
    import ctl_pkg::*;
#(
    parameter int TOTAL_BITS = TOTAL_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [TOTAL_BITS-1:0] tour_length;
    logic                  overflowed;

    modport source (output valid, output tour_length, output overflowed, input ready);
    modport sink (input valid, input tour_length, input overflowed, output ready);
endinterface

### src/closed_tour_length.sv
`timescale 1ns / 1ps
// A city is taken in the idle state. Each leg then runs the diff, multiply and
// accumulate states in circle mode, plus the sum and root states in square mode;
// the root unit retires one root bit per cycle. A city adds one leg, the last
// city two plus the emit state that loads the result word; the first city none.
// Asynchronous active-low reset clears the tour and sets mode 1, radius 256.

module closed_tour_length
    import ctl_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int TOTAL_BITS = TOTAL_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    ctl_city_if.sink              cities,
    ctl_tour_if.source            result
);

    logic                   mode;
    logic [RADIUS_BITS-1:0] radius;
    ctl_cmd_t               cmd;
    ctl_status_t            status;
    logic                   in_ready;

    ctl_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .mode    (mode),
        .radius  (radius)
    );

    ctl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cities.valid),
        .in_last  (cities.last_city),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    ctl_datapath #(
        .COORD_BITS (COORD_BITS),
        .TOTAL_BITS (TOTAL_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .mode       (mode),
        .radius     (radius),
        .in_x       (cities.x_coord),
        .in_y       (cities.y_coord),
        .in_last    (cities.last_city),
        .out_ready  (result.ready),
        .out_valid  (result.valid),
        .out_length (result.tour_length),
        .out_ovf    (result.overflowed)
    );

    assign cities.ready = in_ready;

endmodule

### src/ctl_regs.sv
`timescale 1ns / 1ps

module ctl_regs
    import ctl_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready,
    output logic                   mode,
    output logic [RADIUS_BITS-1:0] radius
);

    logic                   mode_reg;
    logic                   mode_next;
    logic [RADIUS_BITS-1:0] radius_reg;
    logic [RADIUS_BITS-1:0] radius_next;
    logic                   wr_en;
    reg_idx_t               idx;

    // Registers sit on word boundaries, so only the word index is decoded.
    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        mode_next   = mode_reg;
        radius_next = radius_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_MODE:   mode_next   = pwdata[0];
                REG_RADIUS: radius_next = pwdata[RADIUS_BITS-1:0];
                default:    mode_next   = mode_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_MODE:   prdata = APB_DATA_W'(mode_reg);
            REG_RADIUS: prdata = APB_DATA_W'(radius_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_RESET;
            radius_reg <= RADIUS_RESET;
        end
        else
        begin
            mode_reg   <= mode_next;
            radius_reg <= radius_next;
        end
    end

    assign mode   = mode_reg;
    assign radius = radius_reg;

endmodule

### src/ctl_ctrl.sv
`timescale 1ns / 1ps

module ctl_ctrl
    import ctl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_last,
    output logic        in_ready,
    input  ctl_status_t status,
    output ctl_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    leg_t   leg_reg;
    leg_t   leg_next;

    always_comb
    begin
        state_next = state_reg;
        leg_next   = leg_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    leg_next = LEG_STEP;
                    // The first city of a tour adds no leg; alone it closes at zero.
                    if (status.have_first)
                        state_next = S_DIFF;
                    else if (in_last)
                        state_next = S_EMIT;
                end
            end
            S_DIFF: state_next = S_MUL;
            S_MUL:  state_next = (status.mode == MODE_SQUARE) ? S_SUM : S_ACC;
            S_SUM:  state_next = S_ROOT;
            S_ROOT:
            begin
                if (status.root_done)
                    state_next = S_ACC;
            end
            S_ACC:
            begin
                if (status.last && leg_reg == LEG_STEP)
                begin
                    leg_next   = LEG_CLOSE;
                    state_next = S_DIFF;
                end
                else if (status.last)
                    state_next = S_EMIT;
                else
                    state_next = S_IDLE;
            end
            S_EMIT:
            begin
                if (status.out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready      = (state_reg == S_IDLE);
        cmd           = '0;
        cmd.leg_sel   = leg_reg;
        cmd.capture   = (state_reg == S_IDLE) && in_valid;
        cmd.diff_en   = (state_reg == S_DIFF);
        cmd.mul_en    = (state_reg == S_MUL);
        cmd.root_init = (state_reg == S_SUM);
        cmd.root_step = (state_reg == S_ROOT);
        cmd.acc_en    = (state_reg == S_ACC);
        cmd.emit      = (state_reg == S_EMIT) && status.out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            leg_reg   <= LEG_STEP;
        end
        else
        begin
            state_reg <= state_next;
            leg_reg   <= leg_next;
        end
    end

endmodule

### src/ctl_datapath.sv
`timescale 1ns / 1ps

module ctl_datapath
    import ctl_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int TOTAL_BITS = TOTAL_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  ctl_cmd_t               cmd,
    output ctl_status_t            status,
    input  logic                   mode,
    input  logic [RADIUS_BITS-1:0] radius,
    input  logic [COORD_BITS-1:0]  in_x,
    input  logic [COORD_BITS-1:0]  in_y,
    input  logic                   in_last,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic [TOTAL_BITS-1:0]  out_length,
    output logic                   out_ovf
);

    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int RAD_W  = 2 * COORD_BITS + 2;
    localparam int ROOT_W = COORD_BITS + 1;
    localparam int REM_W  = COORD_BITS + 3;
    localparam int CNT_W  = $clog2(ROOT_W);
    localparam int LEG_W  = RADIUS_BITS + COORD_BITS;
    localparam int SUM_W  = ((LEG_W > TOTAL_BITS) ? LEG_W : TOTAL_BITS) + 1;

    localparam logic [COORD_BITS-1:0] HALF_TURN = COORD_BITS'(1) << (COORD_BITS - 1);
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

    // Tour points: first city, previous city (a) and current city (b).
    logic [COORD_BITS-1:0] first_x_reg, first_y_reg;
    logic [COORD_BITS-1:0] a_x_reg, a_y_reg;
    logic [COORD_BITS-1:0] b_x_reg, b_y_reg;
    logic                  last_reg;
    logic                  have_first_reg, have_first_next;

    logic [COORD_BITS-1:0] dx_reg, dy_reg, gap_reg;
    logic [SQ_W-1:0]       sqx_reg, sqy_reg;
    logic [LEG_W-1:0]      arc_reg;

    logic [RAD_W-1:0]      rad_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [ROOT_W-1:0]     root_reg;
    logic [CNT_W-1:0]      cnt_reg;

    logic [TOTAL_BITS-1:0] total_reg, total_next;
    logic                  sat_reg, sat_next;
    logic                  out_valid_reg, out_valid_next;
    logic [TOTAL_BITS-1:0] out_length_reg;
    logic                  out_ovf_reg;

    logic [COORD_BITS-1:0] op_ax, op_ay, op_bx, op_by;
    logic [COORD_BITS-1:0] gap_raw, gap_fold;
    logic [REM_W-1:0]      rem_sh, trial;
    logic                  root_ge;
    logic [LEG_W-1:0]      inc;
    logic [SUM_W-1:0]      sum;

    // Leg end points.
    always_comb
    begin
        if (cmd.leg_sel == LEG_CLOSE)
        begin
            op_ax = b_x_reg;
            op_ay = b_y_reg;
            op_bx = first_x_reg;
            op_by = first_y_reg;
        end
        else
        begin
            op_ax = a_x_reg;
            op_ay = a_y_reg;
            op_bx = b_x_reg;
            op_by = b_y_reg;
        end
    end

    // The angular gap is folded onto the shorter arc.
    assign gap_raw  = op_ax - op_bx;
    assign gap_fold = (gap_raw > HALF_TURN) ? (~gap_raw + COORD_BITS'(1)) : gap_raw;

    // One step of the restoring square root: two radicand bits per cycle.
    assign rem_sh  = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial   = {root_reg, 2'b01};
    assign root_ge = (rem_sh >= trial);

    assign inc = (mode == MODE_SQUARE) ? LEG_W'(root_reg) : arc_reg;
    assign sum = SUM_W'(total_reg) + SUM_W'(inc);

    always_comb
    begin
        total_next      = total_reg;
        sat_next        = sat_reg;
        have_first_next = have_first_reg;
        if (cmd.capture)
            have_first_next = 1'b1;
        if (cmd.acc_en)
        begin
            if (sum > SUM_W'(TOTAL_MAX))
            begin
                total_next = TOTAL_MAX;
                sat_next   = 1'b1;
            end
            else
                total_next = sum[TOTAL_BITS-1:0];
        end
        if (cmd.emit)
        begin
            total_next      = '0;
            sat_next        = 1'b0;
            have_first_next = 1'b0;
        end
    end

    always_comb
    begin
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg      <= '0;
            sat_reg        <= 1'b0;
            have_first_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            total_reg      <= total_next;
            sat_reg        <= sat_next;
            have_first_reg <= have_first_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            a_x_reg  <= b_x_reg;
            a_y_reg  <= b_y_reg;
            b_x_reg  <= in_x;
            b_y_reg  <= in_y;
            last_reg <= in_last;
            if (!have_first_reg)
            begin
                first_x_reg <= in_x;
                first_y_reg <= in_y;
            end
        end
        if (cmd.diff_en)
        begin
            dx_reg  <= (op_ax > op_bx) ? (op_ax - op_bx) : (op_bx - op_ax);
            dy_reg  <= (op_ay > op_by) ? (op_ay - op_by) : (op_by - op_ay);
            gap_reg <= gap_fold;
        end
        if (cmd.mul_en)
        begin
            sqx_reg <= SQ_W'(dx_reg) * SQ_W'(dx_reg);
            sqy_reg <= SQ_W'(dy_reg) * SQ_W'(dy_reg);
            arc_reg <= LEG_W'(radius) * LEG_W'(gap_reg);
        end
        if (cmd.root_init)
        begin
            rad_reg  <= RAD_W'(sqx_reg) + RAD_W'(sqy_reg);
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= '0;
        end
        else if (cmd.root_step)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= root_ge ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[ROOT_W-2:0], root_ge};
            cnt_reg  <= cnt_reg + CNT_W'(1);
        end
        if (cmd.emit)
        begin
            out_length_reg <= total_reg;
            out_ovf_reg    <= sat_reg;
        end
    end

    always_comb
    begin
        status            = '0;
        status.have_first = have_first_reg;
        status.last       = last_reg;
        status.root_done  = (cnt_reg == CNT_W'(ROOT_W - 1));
        status.out_free   = !out_valid_reg || out_ready;
        status.mode       = mode;
    end

    assign out_valid  = out_valid_reg;
    assign out_length = out_length_reg;
    assign out_ovf    = out_ovf_reg;

endmodule

### src/ctl_checker.sv
`timescale 1ns / 1ps

module ctl_checker
    import ctl_pkg::*;
#(
    parameter int TOTAL_BITS = TOTAL_BITS_DEF
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [TOTAL_BITS-1:0] tour_length,
    input logic                  overflowed
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(tour_length) && $stable(overflowed))
        else $error("result word changed while stalled");

    // A result is loaded only from the emit state, which never takes a city.
    a_emit_gap: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_valid && in_ready))
        else $error("result appeared right after a city was taken");

    // Once saturated the total stays pinned at its maximum.
    a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflowed |-> &tour_length)
        else $error("overflowed result is not at full scale");

endmodule

bind closed_tour_length ctl_checker #(
    .TOTAL_BITS (TOTAL_BITS)
) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (cities.valid),
    .in_ready    (cities.ready),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .tour_length (result.tour_length),
    .overflowed  (result.overflowed)
);
